// ----- sv/tarw_pkg.sv -----
// tarw_pkg: types, constants and small decode functions for the tar header walker.
// No dependencies; every other file in sv/ depends on it.
package tarw_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int SIZE_W      = 36;
  localparam int CHK_W       = 24;
  localparam int SUM_W       = 17;
  localparam int BLKIDX_W    = 32;
  localparam int LEFT_W      = SIZE_W - POS_W;

  localparam int QUEUE_DEPTH_DEF = 2;

  // header field offsets within a block
  localparam logic [POS_W-1:0] BLOCK_LAST = POS_W'(BLOCK_BYTES - 1);
  localparam logic [POS_W-1:0] SIZE_LO    = POS_W'(124);
  localparam logic [POS_W-1:0] SIZE_HI    = POS_W'(135);
  localparam logic [POS_W-1:0] CHK_LO     = POS_W'(148);
  localparam logic [POS_W-1:0] CHK_HI     = POS_W'(155);
  localparam logic [POS_W-1:0] TYPE_OFS   = POS_W'(156);
  localparam logic [POS_W-1:0] MAGIC_LO   = POS_W'(257);
  localparam logic [POS_W-1:0] MAGIC_HI   = POS_W'(261);

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_DIR   = 8'h35;
  localparam logic [7:0] CH_LONG  = 8'h4c;

  typedef enum logic [1:0] {
    EV_ENTRY = 2'd0,
    EV_END   = 2'd1,
    EV_CLEAN = 2'd2,
    EV_TRUNC = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    KIND_REG   = 2'd0,
    KIND_DIR   = 2'd1,
    KIND_LONG  = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    MG_EMPTY,
    MG_MATCH,
    MG_BAD
  } magic_t;

  // One queue entry: a leading result plus an optional trailing end-of-stream event.
  typedef struct packed {
    event_t                ev0;
    kind_t                 kind;
    logic [7:0]            type_byte;
    logic [SIZE_W-1:0]     size;
    logic [BLKIDX_W-1:0]   data_block;
    logic                  chk_ok;
    logic                  magic_ok;
    logic                  has2;
    event_t                ev1;
  } pkt_t;

  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } push_t;

  // "ustar" by offset from the start of the magic field
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h75;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic kind_t kind_of(input logic [7:0] t);
    kind_t k;
    unique case (t)
      CH_NUL, CH_ZERO: k = KIND_REG;
      CH_DIR:          k = KIND_DIR;
      CH_LONG:         k = KIND_LONG;
      default:         k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/tarw_if.sv -----
// tarw_if: valid/ready channel interfaces for archive bytes and walker results.
// Depends on tarw_pkg for field widths.
interface tarw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface tarw_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     event_res;
  logic [1:0]                     entry_kind;
  logic [7:0]                     type_byte;
  logic [tarw_pkg::SIZE_W-1:0]    entry_size;
  logic [tarw_pkg::BLKIDX_W-1:0]  data_block;
  logic                           checksum_ok;
  logic                           magic_ok;
  logic                           last_result;

  modport source (output valid, event_res, entry_kind, type_byte, entry_size, data_block,
                  checksum_ok, magic_ok, last_result, input ready);
  modport sink   (input valid, event_res, entry_kind, type_byte, entry_size, data_block,
                  checksum_ok, magic_ok, last_result, output ready);
endinterface

// ----- sv/tarw_front.sv -----
// tarw_front: per-byte block walker; parses header fields and emits result packets.
// Depends on tarw_pkg and tarw_in_if.
module tarw_front (
  input  logic              clk,
  input  logic              rst_n,
  tarw_in_if.sink           in_ch,
  input  logic              q_full,
  output tarw_pkg::push_t   push
);
  import tarw_pkg::*;

  logic [POS_W-1:0]    pos_r,   pos_nxt;
  phase_t              phase_r, phase_nxt, phase_aft;
  logic [SUM_W-1:0]    sum_r,   sum_nxt;
  logic                zero_r,  zero_nxt;
  logic [SIZE_W-1:0]   size_r,  size_nxt;
  logic                sstop_r, sstop_nxt;
  logic [CHK_W-1:0]    chk_r,   chk_nxt;
  logic                cstop_r, cstop_nxt;
  logic [7:0]          type_r,  type_nxt;
  magic_t              magic_r, magic_nxt;
  logic [LEFT_W-1:0]   left_r,  left_nxt;
  logic [BLKIDX_W-1:0] blk_r,   blk_nxt;

  logic [7:0]        b;
  logic              fire, fin, blk_end, hdr_end, ent, endm, tail;
  event_t            tail_ev;
  logic              is_oct, in_size, in_chk, first;
  logic [2:0]        dig;
  logic [SIZE_W-1:0] size_m1;

  // header-path values after this byte
  logic [SUM_W-1:0]  h_sum;
  logic              h_zero, h_sstop, h_cstop;
  logic [SIZE_W-1:0] h_size;
  logic [CHK_W-1:0]  h_chk;
  logic [7:0]        h_type;
  magic_t            h_magic;

  assign in_ch.ready = !q_full;
  assign fire    = in_ch.valid && in_ch.ready;
  assign b       = in_ch.data_byte;
  assign fin     = in_ch.final_byte;
  assign blk_end = (pos_r == BLOCK_LAST);
  assign first   = (pos_r == '0);
  assign is_oct  = (b >= CH_ZERO) && (b <= CH_SEVEN);
  assign dig     = b[2:0];
  assign in_size = (pos_r >= SIZE_LO) && (pos_r <= SIZE_HI);
  assign in_chk  = (pos_r >= CHK_LO) && (pos_r <= CHK_HI);

  // Header datapath; block offset 0 starts from cleared fields.
  always_comb begin
    logic [SUM_W-1:0]  c_sum;
    logic [SIZE_W-1:0] c_size;
    logic [CHK_W-1:0]  c_chk;
    logic              c_zero, c_sstop, c_cstop;
    logic [7:0]        c_type;
    magic_t            c_magic;
    c_sum   = first ? '0 : sum_r;
    c_zero  = first ? 1'b1 : zero_r;
    c_size  = first ? '0 : size_r;
    c_sstop = first ? 1'b0 : sstop_r;
    c_chk   = first ? '0 : chk_r;
    c_cstop = first ? 1'b0 : cstop_r;
    c_type  = first ? CH_NUL : type_r;
    c_magic = first ? MG_EMPTY : magic_r;

    h_sum  = c_sum + SUM_W'(in_chk ? CH_SPACE : b);
    h_zero = c_zero && (b == CH_NUL);

    h_size  = c_size;
    h_sstop = c_sstop;
    if (in_size && !c_sstop) begin
      if (is_oct) h_size = {c_size[SIZE_W-4:0], dig};
      else        h_sstop = 1'b1;
    end

    h_chk   = c_chk;
    h_cstop = c_cstop;
    if (in_chk && !c_cstop) begin
      if (is_oct) h_chk = {c_chk[CHK_W-4:0], dig};
      else        h_cstop = 1'b1;
    end

    h_type = (pos_r == TYPE_OFS) ? b : c_type;

    h_magic = c_magic;
    if (pos_r == MAGIC_LO) begin
      if (b == CH_NUL)             h_magic = MG_EMPTY;
      else if (b == magic_char(3'd0)) h_magic = MG_MATCH;
      else                         h_magic = MG_BAD;
    end else if ((pos_r > MAGIC_LO) && (pos_r <= MAGIC_HI) && (c_magic == MG_MATCH) &&
                 (b != magic_char(3'(pos_r - MAGIC_LO)))) begin
      h_magic = MG_BAD;
    end
  end

  assign hdr_end = fire && blk_end && (phase_r == PH_HEADER);
  assign ent     = hdr_end && !h_zero;
  assign endm    = hdr_end && h_zero;
  assign size_m1 = h_size - SIZE_W'(1);

  // Phase: next state
  always_comb begin
    phase_aft = phase_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (hdr_end) begin
          if (h_zero)             phase_aft = PH_DONE;
          else if (h_size != '0)  phase_aft = PH_DATA;
        end
      end
      PH_DATA: begin
        if (fire && blk_end && (left_r == '0)) phase_aft = PH_HEADER;
      end
      PH_DONE: phase_aft = PH_DONE;
      default: phase_aft = PH_HEADER;
    endcase
    phase_nxt = (fire && fin) ? PH_HEADER : phase_aft;
  end

  // Phase: outputs (result packet)
  always_comb begin
    tail    = fire && fin && (phase_aft != PH_DONE);
    tail_ev = ((phase_aft == PH_HEADER) && blk_end) ? EV_CLEAN : EV_TRUNC;

    push                    = '0;
    push.valid              = ent || endm || tail;
    push.pkt.ev0            = ent ? EV_ENTRY : (endm ? EV_END : tail_ev);
    push.pkt.has2           = (ent || endm) && tail;
    push.pkt.ev1            = tail_ev;
    if (ent) begin
      push.pkt.kind       = kind_of(h_type);
      push.pkt.type_byte  = h_type;
      push.pkt.size       = h_size;
      push.pkt.data_block = blk_r + BLKIDX_W'(1);
      push.pkt.chk_ok     = (h_chk == CHK_W'(h_sum));
      push.pkt.magic_ok   = (h_magic != MG_BAD);
    end
  end

  // Counters and header registers
  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    zero_nxt  = zero_r;
    size_nxt  = size_r;
    sstop_nxt = sstop_r;
    chk_nxt   = chk_r;
    cstop_nxt = cstop_r;
    type_nxt  = type_r;
    magic_nxt = magic_r;
    left_nxt  = left_r;
    blk_nxt   = blk_r;
    if (fire) begin
      if (phase_r == PH_HEADER) begin
        sum_nxt   = h_sum;
        zero_nxt  = h_zero;
        size_nxt  = h_size;
        sstop_nxt = h_sstop;
        chk_nxt   = h_chk;
        cstop_nxt = h_cstop;
        type_nxt  = h_type;
        magic_nxt = h_magic;
      end
      pos_nxt = blk_end ? '0 : pos_r + POS_W'(1);
      if (blk_end) begin
        blk_nxt = blk_r + BLKIDX_W'(1);
        if (ent && (h_size != '0)) begin
          left_nxt = size_m1[SIZE_W-1:POS_W];
        end else if ((phase_r == PH_DATA) && (left_r != '0)) begin
          left_nxt = left_r - LEFT_W'(1);
        end
      end
      if (fin) begin
        pos_nxt   = '0;
        sum_nxt   = '0;
        zero_nxt  = 1'b1;
        size_nxt  = '0;
        sstop_nxt = 1'b0;
        chk_nxt   = '0;
        cstop_nxt = 1'b0;
        type_nxt  = CH_NUL;
        magic_nxt = MG_EMPTY;
        left_nxt  = '0;
        blk_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      sum_r   <= '0;
      zero_r  <= 1'b1;
      size_r  <= '0;
      sstop_r <= 1'b0;
      chk_r   <= '0;
      cstop_r <= 1'b0;
      type_r  <= CH_NUL;
      magic_r <= MG_EMPTY;
      left_r  <= '0;
      blk_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      zero_r  <= zero_nxt;
      size_r  <= size_nxt;
      sstop_r <= sstop_nxt;
      chk_r   <= chk_nxt;
      cstop_r <= cstop_nxt;
      type_r  <= type_nxt;
      magic_r <= magic_nxt;
      left_r  <= left_nxt;
      blk_r   <= blk_nxt;
    end
  end

  // after the end marker only a final byte matters, and it reports nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> !push.valid)
    else $error("tarw_front: result produced after end marker");

  // a final byte always returns the walker to block offset 0
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && fin) |=> (pos_r == '0) && (blk_r == '0) && (phase_r == PH_HEADER))
    else $error("tarw_front: state not restored after final byte");

endmodule

// ----- sv/tarw_queue.sv -----
// tarw_queue: small FIFO of result packets between the front walker and the result port.
// Depends on tarw_pkg.
module tarw_queue #(
  parameter int DEPTH = tarw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tarw_pkg::push_t  push,
  input  logic             pop,
  output tarw_pkg::pkt_t   head,
  output logic             empty,
  output logic             full
);
  import tarw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pkt_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push.pkt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // the front only pushes while the input side is open, so nothing is dropped
  assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !full)
    else $error("tarw_queue: packet pushed into full queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("tarw_queue: occupancy out of range");

endmodule

// ----- sv/tarw_back.sv -----
// tarw_back: unpacks queued packets into one or two result transfers.
// Depends on tarw_pkg and tarw_out_if.
module tarw_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tarw_pkg::pkt_t   head,
  input  logic             empty,
  output logic             pop,
  tarw_out_if.source       out_ch
);
  import tarw_pkg::*;

  logic sub_r, sub_nxt;   // high while the trailing event of the head packet is shown
  logic fire;

  assign out_ch.valid = !empty;
  assign fire         = out_ch.valid && out_ch.ready;
  assign pop          = fire && (sub_r || !head.has2);

  always_comb begin
    out_ch.event_res   = head.ev0;
    out_ch.entry_kind  = head.kind;
    out_ch.type_byte   = head.type_byte;
    out_ch.entry_size  = head.size;
    out_ch.data_block  = head.data_block;
    out_ch.checksum_ok = head.chk_ok;
    out_ch.magic_ok    = head.magic_ok;
    out_ch.last_result = !head.has2;
    if (sub_r) begin
      out_ch.event_res   = head.ev1;
      out_ch.entry_kind  = KIND_REG;
      out_ch.type_byte   = '0;
      out_ch.entry_size  = '0;
      out_ch.data_block  = '0;
      out_ch.checksum_ok = 1'b0;
      out_ch.magic_ok    = 1'b0;
      out_ch.last_result = 1'b1;
    end
  end

  assign sub_nxt = fire ? (!sub_r && head.has2) : sub_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sub_r <= 1'b0;
    else        sub_r <= sub_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (!empty && head.has2))
    else $error("tarw_back: second result without a two-result packet");

endmodule

// ----- sv/tar_archive_header_walker.sv -----
// tar_archive_header_walker: top level of the ustar header walker.
// Depends on tarw_pkg, tarw_if, tarw_front, tarw_queue and tarw_back.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    data_byte[7:0], final_byte
//   out_ch   out  valid/ready    event_res, entry_kind, type_byte, entry_size,
//                                data_block, checksum_ok, magic_ok, last_result
//
// One archive byte per cycle while the queue has room: the front walker updates
// its running header state (sum, octal size/checksum, typeflag, magic, block
// counters) as each byte is accepted. Results are queued and reach out_ch in
// order; a byte that yields two results occupies the result port for two
// transfers. in_ch.ready drops only when the packet queue is full, i.e. when
// the result side has stalled while QUEUE_DEPTH packets are pending.
// Reset is synchronous (rst_n low) and leaves the walker at block 0, header phase.
module tar_archive_header_walker #(
  parameter int QUEUE_DEPTH = tarw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tarw_in_if.sink     in_ch,
  tarw_out_if.source  out_ch
);
  import tarw_pkg::*;

  push_t push;      // front -> queue
  pkt_t  head;      // queue -> back
  logic  q_empty;
  logic  q_full;
  logic  pop;

  // Front: byte parser and block sequencer.
  tarw_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  // Decouples byte intake from result delivery.
  tarw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back: one or two result transfers per packet.
  tarw_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for tar_archive_header_walker; streams generated tar archives
// byte by byte and checks every result against an in-bench walker.
// Depends on tarw_pkg, tarw_if and the RTL under sv/.
module tb;
  import tarw_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // Cycles kept open after the last expected result to catch stray ones.
  localparam int DRAIN_CYCLES = 40;
  // Bytes sent in each random idling phase.
  localparam int PHASE_BYTES = 220;
  localparam logic [39:0] USTAR_TXT = "ustar";

  typedef enum int { SZF_STD, SZF_SPACE, SZF_FULL, SZF_EMPTY, SZF_LEADSP, SZF_BADDIG } size_fmt_t;
  typedef enum int { MGF_USTAR, MGF_GNU, MGF_NONE, MGF_BADHEAD, MGF_BADTAIL } magic_fmt_t;
  typedef enum int { CKF_STD, CKF_WRONG, CKF_FULL, CKF_EMPTY, CKF_MAX } chk_fmt_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } tar_byte_t;

  typedef struct packed {
    event_t              ev;
    kind_t               kind;
    logic [7:0]          tbyte;
    logic [SIZE_W-1:0]   size;
    logic [BLKIDX_W-1:0] blk;
    logic                chk_ok;
    logic                mag_ok;
    logic                last;
  } walk_event_t;

  logic clk;
  logic rst_n;

  tarw_in_if  in_ch ();
  tarw_out_if out_ch ();

  tar_archive_header_walker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Bench-side walker: tracks the archive exactly as the block should and
  // queues the results each accepted byte causes.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]    w_pos       = '0;
  phase_t              w_phase     = PH_HEADER;
  logic [SUM_W-1:0]    w_sum       = '0;
  logic                w_zero      = 1'b1;
  logic [SIZE_W-1:0]   w_size      = '0;
  logic                w_size_done = 1'b0;
  logic [CHK_W-1:0]    w_chk       = '0;
  logic                w_chk_done  = 1'b0;
  logic [7:0]          w_type      = '0;
  magic_t              w_magic     = MG_EMPTY;
  logic [LEFT_W-1:0]   w_left      = '0;
  logic [BLKIDX_W-1:0] w_blk       = '0;

  walk_event_t events_due [$];   // results predicted but not yet seen on out_ch
  tar_byte_t   bytes_to_send [$];
  logic [7:0]  archive_draft [$];
  logic [7:0]  hdr_buf [BLOCK_BYTES];

  int queued_bytes = 0;
  int taken_bytes  = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  logic timed_out  = 1'b0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  walk_event_t mon_want;

  function automatic logic [7:0] ustar_char(input int i);
    return USTAR_TXT[8 * (4 - i) +: 8];
  endfunction

  task automatic clear_header();
    w_sum       = '0;
    w_zero      = 1'b1;
    w_size      = '0;
    w_size_done = 1'b0;
    w_chk       = '0;
    w_chk_done  = 1'b0;
    w_type      = '0;
    w_magic     = MG_EMPTY;
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic fin);
    logic [POS_W-1:0]    pos;
    logic                blk_end;
    logic [BLKIDX_W-1:0] this_blk;
    logic [SIZE_W-1:0]   size_m1;
    walk_event_t         r;
    int                  n_before;
    n_before = events_due.size();
    pos = w_pos;
    if (w_phase == PH_HEADER) begin
      if (pos == '0) clear_header();
      if (b != CH_NUL) w_zero = 1'b0;
      // checksum bytes count as spaces in the header sum
      if (pos >= CHK_LO && pos <= CHK_HI) w_sum = w_sum + SUM_W'(CH_SPACE);
      else w_sum = w_sum + SUM_W'(b);
      if (pos >= SIZE_LO && pos <= SIZE_HI && !w_size_done) begin
        if (b >= CH_ZERO && b <= CH_SEVEN) w_size = {w_size[SIZE_W-4:0], b[2:0]};
        else w_size_done = 1'b1;
      end
      if (pos >= CHK_LO && pos <= CHK_HI && !w_chk_done) begin
        if (b >= CH_ZERO && b <= CH_SEVEN) w_chk = {w_chk[CHK_W-4:0], b[2:0]};
        else w_chk_done = 1'b1;
      end
      if (pos == TYPE_OFS) w_type = b;
      if (pos == MAGIC_LO) begin
        w_magic = (b == CH_NUL) ? MG_EMPTY : (b == ustar_char(0)) ? MG_MATCH : MG_BAD;
      end else if (pos > MAGIC_LO && pos <= MAGIC_HI && w_magic == MG_MATCH &&
                   b != ustar_char(int'(pos - MAGIC_LO))) begin
        w_magic = MG_BAD;
      end
    end

    blk_end = (pos == BLOCK_LAST);
    w_pos   = pos + POS_W'(1);   // wraps to 0 at the block boundary

    if (blk_end) begin
      this_blk = w_blk;
      w_blk    = w_blk + BLKIDX_W'(1);
      if (w_phase == PH_HEADER) begin
        r = '0;
        if (w_zero) begin
          r.ev = EV_END;
          events_due.push_back(r);
          w_phase = PH_DONE;
        end else begin
          r.ev = EV_ENTRY;
          case (w_type)
            CH_NUL, CH_ZERO: r.kind = KIND_REG;
            CH_DIR:          r.kind = KIND_DIR;
            CH_LONG:         r.kind = KIND_LONG;
            default:         r.kind = KIND_OTHER;
          endcase
          r.tbyte  = w_type;
          r.size   = w_size;
          r.blk    = this_blk + BLKIDX_W'(1);
          r.chk_ok = (w_chk == CHK_W'(w_sum));
          r.mag_ok = (w_magic != MG_BAD);
          events_due.push_back(r);
          if (w_size != '0) begin
            // block count held minus one so the full 36-bit size fits
            size_m1 = w_size - SIZE_W'(1);
            w_left  = size_m1[SIZE_W-1:POS_W];
            w_phase = PH_DATA;
          end
        end
      end else if (w_phase == PH_DATA) begin
        if (w_left == '0) w_phase = PH_HEADER;
        else w_left = w_left - LEFT_W'(1);
      end
    end

    if (fin) begin
      if (w_phase != PH_DONE) begin
        r = '0;
        r.ev = (w_phase == PH_HEADER && w_pos == '0) ? EV_CLEAN : EV_TRUNC;
        events_due.push_back(r);
      end
      // next byte starts a fresh archive
      w_pos   = '0;
      w_phase = PH_HEADER;
      w_left  = '0;
      w_blk   = '0;
      clear_header();
    end

    if (events_due.size() > n_before) events_due[events_due.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one byte per transfer from bytes_to_send, with random sender gaps.
  // Valid is held with stable payload until the transfer happens.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.data_byte  <= '0;
      in_ch.final_byte <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        walk_byte(in_ch.data_byte, in_ch.final_byte);
        taken_bytes <= taken_bytes + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid      <= 1'b1;
          in_ch.data_byte  <= bytes_to_send[0].b;
          in_ch.final_byte <= bytes_to_send[0].fin;
          bytes_to_send.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure; each result transfer is checked against the
  // oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (events_due.size() == 0) begin
          $error("result with none pending: event_res %0d", out_ch.event_res);
          mismatches++;
        end else begin
          mon_want = events_due.pop_front();
          check_field("event_res", 64'(mon_want.ev), 64'(out_ch.event_res));
          check_field("entry_kind", 64'(mon_want.kind), 64'(out_ch.entry_kind));
          check_field("type_byte", 64'(mon_want.tbyte), 64'(out_ch.type_byte));
          check_field("entry_size", 64'(mon_want.size), 64'(out_ch.entry_size));
          check_field("data_block", 64'(mon_want.blk), 64'(out_ch.data_block));
          check_field("checksum_ok", 64'(mon_want.chk_ok), 64'(out_ch.checksum_ok));
          check_field("magic_ok", 64'(mon_want.mag_ok), 64'(out_ch.magic_ok));
          check_field("last_result", 64'(mon_want.last), 64'(out_ch.last_result));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any transfer on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      if (!timed_out) $error("no transfer for %0d cycles", QUIET_LIMIT);
      timed_out <= 1'b1;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Archive assembly
  // ---------------------------------------------------------------------------
  task automatic put_octal(input int ofs, input int ndig, input logic [SIZE_W-1:0] v);
    for (int i = 0; i < ndig; i++) begin
      hdr_buf[ofs + i] = CH_ZERO + 8'((v >> (3 * (ndig - 1 - i))) & 36'd7);
    end
  endtask

  // Builds one header block into archive_draft; parsed is the size the walker
  // will read back from the size field as written.
  task automatic put_header(input logic [7:0] tflag, input logic [SIZE_W-1:0] size,
                            input size_fmt_t sf, input magic_fmt_t mf, input chk_fmt_t cf,
                            output logic [SIZE_W-1:0] parsed);
    logic [SUM_W-1:0] sum;
    logic [7:0]       c;
    int               k;
    for (int i = 0; i < BLOCK_BYTES; i++) hdr_buf[i] = CH_NUL;
    // name: nonzero first byte keeps the block from reading as an end marker
    hdr_buf[0] = 8'h61 + 8'($urandom_range(25));
    k = $urandom_range(99);
    for (int i = 1; i < k; i++) hdr_buf[i] = 8'($urandom_range(255));
    put_octal(100, 7, SIZE_W'($urandom_range(511)));
    parsed = size;
    case (sf)
      SZF_STD:    put_octal(124, 11, size);
      SZF_SPACE: begin
        put_octal(124, 11, size);
        hdr_buf[135] = CH_SPACE;
      end
      SZF_FULL:   put_octal(124, 12, size);
      SZF_EMPTY:  parsed = '0;
      SZF_LEADSP: begin
        // leading blank is not skipped: field reads as zero
        hdr_buf[124] = CH_SPACE;
        put_octal(125, 10, size);
        parsed = '0;
      end
      default: begin
        // '8' or '9' cuts the field short
        put_octal(124, 11, size);
        k = $urandom_range(10);
        hdr_buf[124 + k] = 8'h38 + 8'($urandom_range(1));
        parsed = size >> (3 * (11 - k));
      end
    endcase
    hdr_buf[TYPE_OFS] = tflag;
    case (mf)
      MGF_USTAR: begin
        for (int i = 0; i < 5; i++) hdr_buf[MAGIC_LO + i] = ustar_char(i);
        hdr_buf[263] = CH_ZERO;
        hdr_buf[264] = CH_ZERO;
      end
      MGF_GNU: begin
        for (int i = 0; i < 5; i++) hdr_buf[MAGIC_LO + i] = ustar_char(i);
        hdr_buf[262] = CH_SPACE;
        hdr_buf[263] = CH_SPACE;
      end
      MGF_BADHEAD: begin
        c = 8'($urandom_range(1, 255));
        if (c == ustar_char(0)) c = c + 8'd1;
        hdr_buf[MAGIC_LO] = c;
        for (int i = 1; i < 5; i++) hdr_buf[MAGIC_LO + i] = ustar_char(i);
      end
      MGF_BADTAIL: begin
        for (int i = 0; i < 5; i++) hdr_buf[MAGIC_LO + i] = ustar_char(i);
        k = $urandom_range(1, 4);
        c = 8'($urandom_range(255));
        if (c == ustar_char(k)) c = c ^ 8'h01;
        hdr_buf[MAGIC_LO + k] = c;
      end
      default: ;
    endcase
    sum = SUM_W'(8 * CH_SPACE);
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (i < CHK_LO || i > CHK_HI) sum = sum + SUM_W'(hdr_buf[i]);
    end
    case (cf)
      CKF_STD: begin
        put_octal(148, 6, SIZE_W'(sum));
        hdr_buf[155] = CH_SPACE;
      end
      CKF_WRONG: begin
        put_octal(148, 6, SIZE_W'(sum + SUM_W'(1)));
        hdr_buf[155] = CH_SPACE;
      end
      CKF_FULL: put_octal(148, 8, SIZE_W'(sum));
      CKF_MAX:  for (int i = 0; i < 8; i++) hdr_buf[CHK_LO + i] = CH_SEVEN;
      default: ;
    endcase
    for (int i = 0; i < BLOCK_BYTES; i++) archive_draft.push_back(hdr_buf[i]);
  endtask

  // Data for an entry, padded to whole blocks.
  task automatic put_data(input logic [SIZE_W-1:0] nbytes);
    int nblk;
    nblk = int'((nbytes + 36'd511) >> 9);
    repeat (nblk * BLOCK_BYTES) archive_draft.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_zero_block();
    repeat (BLOCK_BYTES) archive_draft.push_back(CH_NUL);
  endtask

  // Queues the first cut bytes of the draft, final flag on the last one.
  // A cut outside 1..size sends the whole draft.
  task automatic emit_archive(input int cut);
    tar_byte_t tb_byte;
    if (cut < 1 || cut > archive_draft.size()) cut = archive_draft.size();
    for (int i = 0; i < cut; i++) begin
      tb_byte.b   = archive_draft[i];
      tb_byte.fin = (i == cut - 1);
      bytes_to_send.push_back(tb_byte);
    end
    queued_bytes += cut;
    archive_draft.delete();
  endtask

  // Mostly well-formed archives with random content and endings; a quarter
  // are stray bytes or a random block.  At most limit bytes are sent: a longer
  // archive is cut at a random point inside that window.
  task automatic random_archive(input int limit);
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] parsed;
    logic [7:0]        tflag;
    size_fmt_t         sf;
    magic_fmt_t        mf;
    chk_fmt_t          cf;
    int                n;
    int                cut;
    if ($urandom_range(99) < 25) begin
      n = ($urandom_range(3) == 0) ? BLOCK_BYTES + $urandom_range(20) : $urandom_range(1, 40);
      repeat (n) archive_draft.push_back(8'($urandom_range(255)));
      cut = n;
    end else begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(5))
          0:       tflag = CH_NUL;
          1:       tflag = CH_ZERO;
          2:       tflag = CH_DIR;
          3:       tflag = CH_LONG;
          default: tflag = 8'($urandom_range(255));
        endcase
        case ($urandom_range(3))
          0:       size = '0;
          1:       size = SIZE_W'($urandom_range(1, 512));
          2:       size = SIZE_W'($urandom_range(513, 1536));
          default: size = SIZE_W'($urandom_range(1, 80));
        endcase
        sf = ($urandom_range(99) < 60) ? SZF_STD : size_fmt_t'($urandom_range(SZF_BADDIG));
        mf = ($urandom_range(99) < 60) ? MGF_USTAR : magic_fmt_t'($urandom_range(MGF_BADTAIL));
        cf = ($urandom_range(99) < 70) ? CKF_STD : chk_fmt_t'($urandom_range(CKF_MAX));
        put_header(tflag, size, sf, mf, cf, parsed);
        put_data(parsed);
      end
      case ($urandom_range(5))
        0, 1: begin
          put_zero_block();
          put_zero_block();
        end
        2: begin
          // junk after the end marker is ignored
          put_zero_block();
          repeat ($urandom_range(1, 30)) archive_draft.push_back(8'($urandom_range(255)));
        end
        3:       ;   // no end marker: ends clean on a block boundary
        default: put_zero_block();
      endcase
      cut = archive_draft.size();
      if ($urandom_range(2) == 0) begin
        // cut short: on a block boundary or anywhere
        if ($urandom_range(1) == 0) cut = BLOCK_BYTES * $urandom_range(1, cut / BLOCK_BYTES);
        else cut = $urandom_range(1, cut);
      end
    end
    if (cut > limit) cut = $urandom_range(1, limit);
    emit_archive(cut);
  endtask

  // Wait until every queued byte has been taken and every result checked.
  task automatic settle();
    do @(negedge clk);
    while (!timed_out && !(taken_bytes == queued_bytes && events_due.size() == 0));
  endtask

  // Random archives totalling PHASE_BYTES bytes under one idling mix.
  task automatic random_phase(input int idle, input int stall);
    int start;
    @(negedge clk);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    start = queued_bytes;
    while (queued_bytes - start < PHASE_BYTES) begin
      random_archive(PHASE_BYTES - (queued_bytes - start));
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [SIZE_W-1:0] p;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // lone bytes at both extremes: truncated mid-block
    archive_draft.push_back(8'h00);
    emit_archive(0);
    archive_draft.push_back(8'hff);
    emit_archive(0);

    // empty entry finished by the final byte: entry then clean end
    put_header(8'hff, '0, SZF_STD, MGF_USTAR, CKF_STD, p);
    emit_archive(0);
    settle();

    // random archives under each idling mix
    random_phase(0, 0);
    random_phase(88, 0);
    random_phase(0, 88);
    random_phase(24, 24);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (events_due.size() != 0) $error("%0d expected results never arrived", events_due.size());
    if (mismatches == 0 && !timed_out && events_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/tarw_pkg.sv
sv/tarw_if.sv
sv/tarw_front.sv
sv/tarw_queue.sv
sv/tarw_back.sv
sv/tar_archive_header_walker.sv
bench/tb.sv
